// File: design/gregorian_date_add_days_unit_assert.svh
// Assertion macros for the date add unit.
// Used by the top level only; no other dependencies.
`ifndef GREGORIAN_DATE_ADD_DAYS_UNIT_ASSERT_SVH
`define GREGORIAN_DATE_ADD_DAYS_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define GDAD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define GDAD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GDAD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define GDAD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: design/gdad_pkg.sv
// Shared types, constants and a calendar function for the date add unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gdad_pkg;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned CountW = 12;

  localparam logic [YearW-1:0]  YearMax  = 14'd9999;
  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthApr = 4'd4;
  localparam logic [MonthW-1:0] MonthJun = 4'd6;
  localparam logic [MonthW-1:0] MonthSep = 4'd9;
  localparam logic [MonthW-1:0] MonthNov = 4'd11;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;

  localparam logic [DayW-1:0] DaysLeapFeb = 5'd29;
  localparam logic [DayW-1:0] DaysFeb     = 5'd28;
  localparam logic [DayW-1:0] DaysShort   = 5'd30;
  localparam logic [DayW-1:0] DaysLong    = 5'd31;

  // Reciprocal of 25, exact for every 14-bit year: q = (y * Recip25) >> Recip25Shift
  localparam logic [14:0]   Recip25      = 15'd20972;
  localparam int unsigned   Recip25Shift = 19;
  localparam int unsigned   ProdW        = YearW + 15;
  localparam int unsigned   QuotW        = ProdW - Recip25Shift;
  localparam logic [4:0]    Div25        = 5'd25;

  typedef struct packed {
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [CountW-1:0] left;
    logic              year_inc;
  } step_t;

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [DayW-1:0] len;
    if (m == MonthFeb) begin
      len = leap ? DaysLeapFeb : DaysFeb;
    end else if (m == MonthApr || m == MonthJun || m == MonthSep || m == MonthNov) begin
      len = DaysShort;
    end else begin
      len = DaysLong;
    end
    return len;
  endfunction

endpackage

`default_nettype wire

// File: design/gregorian_date_add_days_unit.sv
// Top level of the date add unit: sequencer, leap unit and month stepper.
// Depends on gdad_pkg, gdad_leap_unit, gdad_month_step and the assertion header.
//
// Takes a start date and a day count, checks the date against the Gregorian
// calendar and walks forward one month per cycle, pausing at each year boundary
// to recompute the leap flag. The walk runs through the single month stepper.
// in_stall_o is high from acceptance until the result is placed in the output
// register; a result waiting on out_stall_i holds the next one back only once
// that one is ready to be written, at the end of its walk or at the check of an
// invalid start date. An invalid start date, or a result past year 9999, gives
// date_valid_o low and zero fields.
`timescale 1ns / 1ps
`default_nettype none
`include "gregorian_date_add_days_unit_assert.svh"

module gregorian_date_add_days_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [gdad_pkg::DayW-1:0]     start_day_i,
  input  wire logic [gdad_pkg::MonthW-1:0]   start_month_i,
  input  wire logic [gdad_pkg::YearW-1:0]    start_year_i,
  input  wire logic [gdad_pkg::CountW-1:0]   day_count_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [gdad_pkg::DayW-1:0]          due_day_o,
  output logic [gdad_pkg::MonthW-1:0]        due_month_o,
  output logic [gdad_pkg::YearW-1:0]         due_year_o,
  output logic                               date_valid_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LEAP1 = 3'd1;
  localparam logic [2:0] S_LEAP2 = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_WALK  = 3'd4;

  logic [2:0]                    state_q, state_d;
  logic                          chk_q, chk_d;
  logic                          leap_q, leap_d;
  logic [gdad_pkg::DayW-1:0]     day_q, day_d;
  logic [gdad_pkg::MonthW-1:0]   month_q, month_d;
  logic [gdad_pkg::YearW-1:0]    year_q, year_d;
  logic [gdad_pkg::CountW-1:0]   left_q, left_d;

  logic                          out_valid_q, out_valid_d;
  logic [gdad_pkg::DayW-1:0]     res_day_q, res_day_d;
  logic [gdad_pkg::MonthW-1:0]   res_month_q, res_month_d;
  logic [gdad_pkg::YearW-1:0]    res_year_q, res_year_d;
  logic                          res_ok_q, res_ok_d;

  logic                          leap;
  gdad_pkg::step_t               step;
  logic                          in_fire, out_free, start_ok;

  gdad_leap_unit u_leap (
    .clk_i  (clk_i),
    .year_i (year_q),
    .leap_o (leap)
  );

  gdad_month_step u_step (
    .day_i   (day_q),
    .month_i (month_q),
    .left_i  (left_q),
    .leap_i  (leap_q),
    .step_o  (step)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign start_ok = (year_q <= gdad_pkg::YearMax) && (month_q != '0) &&
                    (month_q <= gdad_pkg::MonthDec) && (day_q != '0) &&
                    (day_q <= gdad_pkg::month_len(month_q, leap_q));

  always_comb begin
    state_d     = state_q;
    chk_d       = chk_q;
    leap_d      = leap_q;
    day_d       = day_q;
    month_d     = month_q;
    year_d      = year_q;
    left_d      = left_q;
    out_valid_d = out_valid_q && out_stall_i;
    res_day_d   = res_day_q;
    res_month_d = res_month_q;
    res_year_d  = res_year_q;
    res_ok_d    = res_ok_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          day_d   = start_day_i;
          month_d = start_month_i;
          year_d  = start_year_i;
          left_d  = day_count_i;
          chk_d   = 1'b1;
          state_d = S_LEAP1;
        end
      end
      S_LEAP1: state_d = S_LEAP2;
      S_LEAP2: begin
        leap_d  = leap;
        state_d = chk_q ? S_CHECK : S_WALK;
      end
      S_CHECK: begin
        chk_d = 1'b0;
        if (start_ok) begin
          state_d = S_WALK;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          res_day_d   = '0;
          res_month_d = '0;
          res_year_d  = '0;
          res_ok_d    = 1'b0;
          state_d     = S_IDLE;
        end
      end
      S_WALK: begin
        if (left_q == '0) begin
          // hold until the output register is free
          if (out_free) begin
            out_valid_d = 1'b1;
            res_ok_d    = (year_q <= gdad_pkg::YearMax);
            res_day_d   = res_ok_d ? day_q : '0;
            res_month_d = res_ok_d ? month_q : '0;
            res_year_d  = res_ok_d ? year_q : '0;
            state_d     = S_IDLE;
          end
        end else begin
          day_d   = step.day;
          month_d = step.month;
          left_d  = step.left;
          if (step.year_inc) begin
            year_d  = year_q + gdad_pkg::YearW'(1);
            state_d = S_LEAP1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      chk_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      chk_q       <= chk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    leap_q      <= leap_d;
    day_q       <= day_d;
    month_q     <= month_d;
    year_q      <= year_d;
    left_q      <= left_d;
    res_day_q   <= res_day_d;
    res_month_q <= res_month_d;
    res_year_q  <= res_year_d;
    res_ok_q    <= res_ok_d;
  end

  assign out_valid_o  = out_valid_q;
  assign due_day_o    = res_day_q;
  assign due_month_o  = res_month_q;
  assign due_year_o   = res_year_q;
  assign date_valid_o = res_ok_q;

  `GDAD_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_fire, state_q == S_LEAP1, "accepted transaction did not start")
  `GDAD_ASSERT_NEXT(a_walk_progress, clk_i, rst_ni, state_q == S_WALK && left_q != '0, left_q < $past(left_q), "month walk made no progress")
  `GDAD_ASSERT_IMPL(a_invalid_zero, clk_i, rst_ni, out_valid_o && !date_valid_o, due_day_o == '0 && due_month_o == '0 && due_year_o == '0, "invalid result carries a date")
  `GDAD_ASSERT_IMPL(a_valid_date, clk_i, rst_ni, out_valid_o && date_valid_o, due_day_o != '0 && due_month_o != '0 && due_month_o <= gdad_pkg::MonthDec && due_year_o <= gdad_pkg::YearMax, "valid result out of calendar range")

endmodule

`default_nettype wire

// File: design/gdad_leap_unit.sv
// Leap year test: registered reciprocal multiply, then remainder check.
// Depends on gdad_pkg. Result is valid in the cycle after year_i settles.
`timescale 1ns / 1ps
`default_nettype none

module gdad_leap_unit (
  input  wire logic                        clk_i,
  input  wire logic [gdad_pkg::YearW-1:0]  year_i,
  output logic                             leap_o
);

  logic [gdad_pkg::ProdW-1:0] prod_q;
  logic [gdad_pkg::QuotW-1:0] quot;
  logic [gdad_pkg::YearW-1:0] rem;
  logic                       div4, div16, div25;

  always_ff @(posedge clk_i) begin
    prod_q <= gdad_pkg::ProdW'(year_i) * gdad_pkg::ProdW'(gdad_pkg::Recip25);
  end

  always_comb begin
    quot  = prod_q[gdad_pkg::ProdW-1:gdad_pkg::Recip25Shift];
    rem   = year_i - (gdad_pkg::YearW'(quot) * gdad_pkg::YearW'(gdad_pkg::Div25));
    div25 = (rem == '0);
    div4  = (year_i[1:0] == 2'd0);
    div16 = (year_i[3:0] == 4'd0);
    // divisible by 4 but not by 100, or by 400
    leap_o = (div4 && !div25) || (div16 && div25);
  end

endmodule

`default_nettype wire

// File: design/gdad_month_step.sv
// One step of the month walk: advance to the end of the month or by the rest.
// Depends on gdad_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gdad_month_step (
  input  wire logic [gdad_pkg::DayW-1:0]   day_i,
  input  wire logic [gdad_pkg::MonthW-1:0] month_i,
  input  wire logic [gdad_pkg::CountW-1:0] left_i,
  input  wire logic                        leap_i,
  output gdad_pkg::step_t                  step_o
);

  logic [gdad_pkg::DayW-1:0] len;
  logic [gdad_pkg::DayW:0]   room, take, dsum;

  always_comb begin
    len  = gdad_pkg::month_len(month_i, leap_i);
    room = {1'b0, len} - {1'b0, day_i} + 6'd1;
    take = (left_i < gdad_pkg::CountW'(room)) ? left_i[gdad_pkg::DayW:0] : room;
    dsum = {1'b0, day_i} + take;
    step_o.left     = left_i - gdad_pkg::CountW'(take);
    step_o.year_inc = 1'b0;
    if (dsum > {1'b0, len}) begin
      // roll over into the next month
      step_o.day = gdad_pkg::DayW'(1);
      if (month_i == gdad_pkg::MonthDec) begin
        step_o.month    = gdad_pkg::MonthJan;
        step_o.year_inc = 1'b1;
      end else begin
        step_o.month = month_i + gdad_pkg::MonthW'(1);
      end
    end else begin
      step_o.day   = dsum[gdad_pkg::DayW-1:0];
      step_o.month = month_i;
    end
  end

endmodule

`default_nettype wire

// File: test/gdad_date_checker.sv
// Checker for the date add unit: watches both channels, predicts each due date
// and compares it field by field. Depends on gdad_pkg for widths and calendar constants.
`timescale 1ns / 1ps

module gdad_date_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [gdad_pkg::DayW-1:0]      start_day_i,
  input  logic [gdad_pkg::MonthW-1:0]    start_month_i,
  input  logic [gdad_pkg::YearW-1:0]     start_year_i,
  input  logic [gdad_pkg::CountW-1:0]    day_count_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [gdad_pkg::DayW-1:0]      due_day_i,
  input  logic [gdad_pkg::MonthW-1:0]    due_month_i,
  input  logic [gdad_pkg::YearW-1:0]     due_year_i,
  input  logic                           date_valid_i,
  output int unsigned                    error_count_o,
  output int unsigned                    pending_o
);

  typedef struct packed {
    logic [gdad_pkg::DayW-1:0]   day;
    logic [gdad_pkg::MonthW-1:0] month;
    logic [gdad_pkg::YearW-1:0]  year;
    logic                        valid;
  } due_date_t;

  due_date_t   due_dates_q[$];
  due_date_t   oldest_due;
  int unsigned mismatches = 0;
  int unsigned waiting    = 0;

  assign error_count_o = mismatches;
  assign pending_o     = waiting;

  function automatic bit is_leap_year(input int unsigned year);
    return ((year % 4) == 0 && (year % 100) != 0) || (year % 400) == 0;
  endfunction

  function automatic int unsigned days_in_month(input int unsigned month,
                                                input int unsigned year);
    if (month == gdad_pkg::MonthFeb) begin
      return is_leap_year(year) ? 32'(gdad_pkg::DaysLeapFeb) : 32'(gdad_pkg::DaysFeb);
    end
    if (month == gdad_pkg::MonthApr || month == gdad_pkg::MonthJun ||
        month == gdad_pkg::MonthSep || month == gdad_pkg::MonthNov) begin
      return 32'(gdad_pkg::DaysShort);
    end
    return 32'(gdad_pkg::DaysLong);
  endfunction

  function automatic due_date_t predict_due_date(input logic [gdad_pkg::DayW-1:0]   d,
                                                 input logic [gdad_pkg::MonthW-1:0] m,
                                                 input logic [gdad_pkg::YearW-1:0]  y,
                                                 input logic [gdad_pkg::CountW-1:0] count);
    int unsigned day, month, year, left, len, room, jump;
    bit          ok;
    due_date_t   due;
    day   = 32'(d);
    month = 32'(m);
    year  = 32'(y);
    left  = 32'(count);
    due   = '0;
    ok = year <= gdad_pkg::YearMax && month >= gdad_pkg::MonthJan &&
         month <= gdad_pkg::MonthDec && day >= 1 && day <= days_in_month(month, year);
    if (ok) begin
      // Jump to the first of the next month whenever the count reaches it.
      while (left > 0) begin
        len  = days_in_month(month, year);
        room = len - day + 1;
        jump = (left < room) ? left : room;
        day  += jump;
        left -= jump;
        if (day > len) begin
          day = 1;
          if (month == gdad_pkg::MonthDec) begin
            month = 32'(gdad_pkg::MonthJan);
            year++;
          end else begin
            month++;
          end
        end
      end
      ok = year <= gdad_pkg::YearMax;
    end
    if (ok) begin
      due.day   = gdad_pkg::DayW'(day);
      due.month = gdad_pkg::MonthW'(month);
      due.year  = gdad_pkg::YearW'(year);
      due.valid = 1'b1;
    end
    return due;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) begin
        due_dates_q.push_back(predict_due_date(start_day_i, start_month_i,
                                               start_year_i, day_count_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (due_dates_q.size() == 0) begin
          $error("due date %0d-%0d-%0d (valid %0b) with no transaction waiting",
                 due_year_i, due_month_i, due_day_i, date_valid_i);
          mismatches++;
        end else begin
          oldest_due = due_dates_q.pop_front();
          if (due_day_i !== oldest_due.day) begin
            $error("due_day: expected %0d, got %0d", oldest_due.day, due_day_i);
            mismatches++;
          end
          if (due_month_i !== oldest_due.month) begin
            $error("due_month: expected %0d, got %0d", oldest_due.month, due_month_i);
            mismatches++;
          end
          if (due_year_i !== oldest_due.year) begin
            $error("due_year: expected %0d, got %0d", oldest_due.year, due_year_i);
            mismatches++;
          end
          if (date_valid_i !== oldest_due.valid) begin
            $error("date_valid: expected %0b, got %0b", oldest_due.valid, date_valid_i);
            mismatches++;
          end
        end
      end
      waiting = due_dates_q.size();
    end
  end

endmodule

// File: test/tb_gregorian_date_add_days_unit.sv
// Testbench top for the date add unit: clock, reset, stimulus, receiver and verdict.
// Depends on gdad_pkg, gregorian_date_add_days_unit and gdad_date_checker.
`timescale 1ns / 1ps

module tb_gregorian_date_add_days_unit;

  localparam int unsigned RandomDates  = 1750;
  localparam int unsigned HoldAtItem   = 600;
  localparam int unsigned HoldCycles   = 1500;
  localparam int unsigned SettleCycles = 200;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic [gdad_pkg::DayW-1:0]    start_day;
  logic [gdad_pkg::MonthW-1:0]  start_month;
  logic [gdad_pkg::YearW-1:0]   start_year;
  logic [gdad_pkg::CountW-1:0]  day_count;
  logic                         out_valid;
  logic                         out_stall;
  logic [gdad_pkg::DayW-1:0]    due_day;
  logic [gdad_pkg::MonthW-1:0]  due_month;
  logic [gdad_pkg::YearW-1:0]   due_year;
  logic                         date_valid;

  int unsigned error_count;
  int unsigned pending_dates;
  int unsigned items_sent = 0;
  bit          calm       = 1'b0;

  gregorian_date_add_days_unit dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .start_day_i   (start_day),
    .start_month_i (start_month),
    .start_year_i  (start_year),
    .day_count_i   (day_count),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .due_day_o     (due_day),
    .due_month_o   (due_month),
    .due_year_o    (due_year),
    .date_valid_o  (date_valid)
  );

  gdad_date_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .start_day_i   (start_day),
    .start_month_i (start_month),
    .start_year_i  (start_year),
    .day_count_i   (day_count),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .due_day_i     (due_day),
    .due_month_i   (due_month),
    .due_year_i    (due_year),
    .date_valid_i  (date_valid),
    .error_count_o (error_count),
    .pending_o     (pending_dates)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Mostly short gaps, a few long ones; none during a calm stretch.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 120);
  endfunction

  task automatic send_date(input logic [gdad_pkg::DayW-1:0]   d,
                           input logic [gdad_pkg::MonthW-1:0] m,
                           input logic [gdad_pkg::YearW-1:0]  y,
                           input logic [gdad_pkg::CountW-1:0] count);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    start_day   <= d;
    start_month <= m;
    start_year  <= y;
    day_count   <= count;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Hold the sender until every predicted date has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_dates == 0);
    @(posedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off while the sender keeps going.
  initial begin : receiver
    int unsigned len;
    bit          hold_done;
    hold_done = 1'b0;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!hold_done && items_sent >= HoldAtItem) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        len = pick_gap();
        if (len > 0) begin
          out_stall <= 1'b1;
          repeat (len) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  initial begin : stimulus
    logic [gdad_pkg::DayW-1:0]   d;
    logic [gdad_pkg::MonthW-1:0] m;
    logic [gdad_pkg::YearW-1:0]  y;
    logic [gdad_pkg::CountW-1:0] count;
    int unsigned                 r;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    start_day   = '0;
    start_month = '0;
    start_year  = '0;
    day_count   = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_date(5'd1, 4'd1, 14'd2024, 12'd0);       // zero count keeps the date
    send_date(5'd0, 4'd1, 14'd2024, 12'd5);       // day zero
    send_date(5'd31, 4'd4, 14'd2023, 12'd1);      // day past a 30-day month
    send_date(5'd29, 4'd2, 14'd2000, 12'd1);      // leap by the 400 rule
    send_date(5'd29, 4'd2, 14'd1900, 12'd1);      // century, not leap
    send_date(5'd29, 4'd2, 14'd2024, 12'd365);
    send_date(5'd29, 4'd2, 14'd2023, 12'd0);
    send_date(5'd28, 4'd2, 14'd2023, 12'd1);
    send_date(5'd1, 4'd0, 14'd2020, 12'd1);       // month zero
    send_date(5'd1, 4'd13, 14'd2020, 12'd1);
    send_date(5'd31, 4'd15, 14'd16383, 12'd4095); // every input bit high
    send_date(5'd0, 4'd0, 14'd0, 12'd0);
    send_date(5'd31, 4'd12, 14'd9999, 12'd0);     // last valid date
    send_date(5'd31, 4'd12, 14'd9999, 12'd1);     // carries past year 9999
    send_date(5'd1, 4'd1, 14'd10000, 12'd0);      // year above range
    send_date(5'd29, 4'd2, 14'd0, 12'd4095);      // year zero is leap
    send_date(5'd1, 4'd1, 14'd0, 12'd4095);
    send_date(5'd31, 4'd12, 14'd9990, 12'd4095);
    send_date(5'd15, 4'd6, 14'd9988, 12'd4095);
    send_date(5'd31, 4'd1, 14'd2021, 12'd29);
    send_date(5'd30, 4'd12, 14'd1999, 12'd1);
    send_date(5'd31, 4'd12, 14'd1999, 12'd1);
    send_date(5'd31, 4'd5, 14'd2100, 12'd4095);
    drain();

    for (int unsigned i = 0; i < RandomDates; i++) begin
      calm = (i >= 1000 && i < 1150);
      if (i == 1300) drain();
      r = $urandom_range(0, 99);
      if (r < 20) begin
        // noise over the full width of every field
        d     = gdad_pkg::DayW'($urandom_range(0, 31));
        m     = gdad_pkg::MonthW'($urandom_range(0, 15));
        y     = gdad_pkg::YearW'($urandom_range(0, 16383));
        count = gdad_pkg::CountW'($urandom_range(0, 4095));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10) y = gdad_pkg::YearW'($urandom_range(9985, 9999));
        else if (r < 25) y = gdad_pkg::YearW'($urandom_range(0, 99) * 100);
        else y = gdad_pkg::YearW'($urandom_range(0, 9999));
        m = gdad_pkg::MonthW'($urandom_range(1, 12));
        r = $urandom_range(0, 99);
        // month ends, some of them past the month's length
        if (r < 25) d = gdad_pkg::DayW'($urandom_range(28, 31));
        else if (r < 30) d = 5'd0;
        else d = gdad_pkg::DayW'($urandom_range(1, 28));
        r = $urandom_range(0, 99);
        if (r < 15) count = gdad_pkg::CountW'($urandom_range(0, 40));
        else if (r < 30) count = gdad_pkg::CountW'($urandom_range(4000, 4095));
        else count = gdad_pkg::CountW'($urandom_range(0, 4095));
      end
      send_date(d, m, y, count);
    end
    calm = 1'b0;

    drain();
    repeat (SettleCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #40_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
